// ----- hw/rtl/scfl_pkg.sv -----
`default_nettype none
package scfl_pkg;
  localparam int AddrW = 40;
  localparam int CntW = 32;
  localparam int ClsW = 3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_BAD_FREE  = 3'd3,
    ST_NULL_FREE = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_SLAB_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_LINK,
    BK_HOLD
  } bk_state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/scfl_if.sv -----
`default_nettype none
interface scfl_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_size;
  logic [39:0] block_address;
  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

interface scfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [39:0] granted_address;
  logic [2:0]  size_class;
  logic [31:0] class_allocs;
  logic [31:0] class_frees;
  modport source (output valid, status, granted_address, size_class, class_allocs,
                  class_frees, input ready);
  modport sink (input valid, status, granted_address, size_class, class_allocs,
                class_frees, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/scfl_ram.sv -----
`default_nettype none
module scfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/scfl_front.sv -----
`default_nettype none
module scfl_front #(
  parameter int ClassCount = 8,
  parameter int MinBlockBytes = 64,
  parameter int QW = 60
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  scfl_req_if.sink            req,
  output logic                q_valid,
  input  wire logic           q_ready,
  output logic [QW-1:0]       q_data
);
  import scfl_pkg::*;
  localparam int ClsCountW = $clog2(ClassCount + 1);
  localparam int AQ = 2;

  logic [1:0]    cnt_r;
  logic [QW-1:0] fifo_r [AQ];
  logic          wr_ptr_r, rd_ptr_r;
  logic          push, pop;
  logic [ClsCountW-1:0] cls_raw;
  logic          too_large;
  logic [QW-1:0] entry;

  always_comb begin
    cls_raw = ClsCountW'(ClassCount);
    for (int c = ClassCount - 1; c >= 0; c--) begin
      if ({8'd0, req.request_size} <= (24'(MinBlockBytes) << c)) cls_raw = ClsCountW'(c);
    end
    too_large = (cls_raw == ClsCountW'(ClassCount));
    entry = {req.mode, too_large, 3'(cls_raw), 15'd0, req.block_address};
  end

  assign req.ready = (cnt_r != 2'd2);
  assign push = req.valid && req.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) fifo_r[wr_ptr_r] <= entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && cnt_r == 2'd1 |=> cnt_r == 2'd2) else $error("count step");
endmodule
`default_nettype wire

// ----- hw/rtl/scfl_back.sv -----
`default_nettype none
module scfl_back #(
  parameter int ClassCount = 8,
  parameter int SlabBytes = 8192,
  parameter int PoolSlabs = 64,
  parameter int MinBlockBytes = 64,
  parameter int QW = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire logic [QW-1:0] q_data,
  input  wire logic [39:0] pool_base,
  input  wire logic [6:0]  slab_limit,
  scfl_rsp_if.source       rsp
);
  import scfl_pkg::*;
  localparam int SlotCount = PoolSlabs * SlabBytes / MinBlockBytes;
  localparam int SlotW = $clog2(SlotCount);
  localparam int SlabW = (PoolSlabs > 1) ? $clog2(PoolSlabs) : 1;
  localparam int SlabCntW = $clog2(PoolSlabs + 1);
  localparam int SlabOffW = $clog2(SlabBytes);
  localparam int MinW = $clog2(MinBlockBytes);
  localparam int PerW = $clog2(SlabBytes / MinBlockBytes + 1);
  localparam int CW = (ClassCount > 1) ? $clog2(ClassCount) : 1;
  localparam int PoolW = SlabW + SlabOffW;

  bk_state_t state_r, state_nxt;

  logic              mode_r, big_r;
  logic [2:0]        cls_r;
  logic [39:0]       addr_r;

  logic [SlotW-1:0]  head_r [ClassCount];
  logic              head_v_r [ClassCount];
  logic [PerW-1:0]   carve_rem_r [ClassCount];
  logic [SlabW-1:0]  carve_slab_r [ClassCount];
  logic [SlabCntW-1:0] used_r;
  logic [31:0]       alloc_cnt_r [ClassCount];
  logic [31:0]       free_cnt_r [ClassCount];

  logic [SlotW:0]    link_wdata, link_rdata;
  logic              link_we;
  logic [SlotW-1:0]  link_waddr, link_raddr;

  logic [2:0]        owner_rdata;
  logic [SlabW-1:0]  owner_raddr;
  logic [39:0]       q_off;
  logic              fresh_go;

  logic [2:0]        o_status_r;
  logic [39:0]       o_addr_r;
  logic [2:0]        o_cls_r;
  logic [31:0]       o_alloc_r, o_free_r;

  logic [CW-1:0]     ac;
  logic [CW-1:0]     fc;
  logic [40:0]       fdiff;
  logic [39:0]       off;
  logic              in_pool;
  logic [SlabW-1:0]  fs;
  logic [SlabOffW-1:0] slab_pos;
  logic [2:0]        fcls;
  logic              f_ok;
  logic [PerW-1:0]   fk;
  logic [PerW-1:0]   per;
  logic [SlabCntW-1:0] limit;
  logic [39:0]       carve_off;
  logic [39:0]       fresh_off;
  logic              exec_go;

  scfl_ram #(.Width(SlotW + 1), .Depth(SlotCount)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata));

  // owner tag is looked up while the transaction waits in the queue
  scfl_ram #(.Width(3), .Depth(1 << SlabW)) u_owner (
    .clk(clk), .we(fresh_go), .waddr(SlabW'(used_r)), .wdata(cls_r),
    .raddr(owner_raddr), .rdata(owner_rdata));

  always_comb begin
    ac = CW'(cls_r);
    per = (cls_r <= 3'(SlabOffW - MinW) && int'(cls_r) < ClassCount) ?
          PerW'((SlabBytes / MinBlockBytes) >> cls_r) : '0;
    limit = (slab_limit < 7'(PoolSlabs) || PoolSlabs > 127) ? SlabCntW'(slab_limit)
            : SlabCntW'(PoolSlabs);
    q_off = q_data[39:0] - pool_base;
    owner_raddr = SlabW'(q_off >> SlabOffW);
    fdiff = {1'b0, addr_r} - {1'b0, pool_base};
    off = fdiff[39:0];
    in_pool = !fdiff[40] && (off >> PoolW) == '0;
    fs = SlabW'(off >> SlabOffW);
    slab_pos = SlabOffW'(off);
    fcls = owner_rdata;
    fc = CW'(fcls);
    fk = PerW'(slab_pos >> (MinW + int'(fcls)));
    f_ok = in_pool && (SlabCntW'(fs) < used_r)
           && ((slab_pos & ((SlabOffW'(MinBlockBytes) << fcls) - 1'b1)) == '0)
           && (fk < PerW'((SlabBytes / MinBlockBytes) >> fcls))
           && ((SlabBytes >> MinW) >> fcls) != 0
           && !(carve_slab_r[fc] == fs && fk < carve_rem_r[fc]);
    carve_off = (40'(carve_slab_r[ac]) << SlabOffW)
                + (40'(carve_rem_r[ac] - 1'b1) << (MinW + int'(cls_r)));
    fresh_off = (40'(used_r) << SlabOffW) + (40'(per - 1'b1) << (MinW + int'(cls_r)));
    fresh_go = (state_r == BK_EXEC) && mode_r == MODE_ALLOC && !big_r && !head_v_r[ac]
               && carve_rem_r[ac] == '0 && per != '0 && used_r < limit;
    link_raddr = head_r[ac];
    link_we = (state_r == BK_EXEC) && mode_r == MODE_FREE && addr_r != '0 && f_ok;
    link_waddr = SlotW'(off >> MinW);
    link_wdata = {head_v_r[fc], head_r[fc]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC: state_nxt = (!mode_r && !big_r && head_v_r[ac]) ? BK_LINK : BK_HOLD;
      BK_LINK: state_nxt = BK_HOLD;
      BK_HOLD: if (rsp.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state_r == BK_IDLE);
    rsp.valid = (state_r == BK_HOLD);
    exec_go = (state_r == BK_EXEC);
  end

  assign rsp.status = o_status_r;
  assign rsp.granted_address = o_addr_r;
  assign rsp.size_class = o_cls_r;
  assign rsp.class_allocs = o_alloc_r;
  assign rsp.class_frees = o_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      used_r <= '0;
      for (int c = 0; c < ClassCount; c++) begin
        head_v_r[c] <= 1'b0;
        carve_rem_r[c] <= '0;
        carve_slab_r[c] <= '0;
        alloc_cnt_r[c] <= '0;
        free_cnt_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exec_go && mode_r == MODE_ALLOC && !big_r) begin
        if (head_v_r[ac]) begin
          alloc_cnt_r[ac] <= alloc_cnt_r[ac] + 1'b1;
        end else if (carve_rem_r[ac] != '0) begin
          carve_rem_r[ac] <= carve_rem_r[ac] - 1'b1;
          alloc_cnt_r[ac] <= alloc_cnt_r[ac] + 1'b1;
        end else if (per != '0 && used_r < limit) begin
          carve_slab_r[ac] <= SlabW'(used_r);
          carve_rem_r[ac] <= per - 1'b1;
          used_r <= used_r + 1'b1;
          alloc_cnt_r[ac] <= alloc_cnt_r[ac] + 1'b1;
        end
      end
      if (link_we) begin
        head_r[fc] <= link_waddr;
        head_v_r[fc] <= 1'b1;
        free_cnt_r[fc] <= free_cnt_r[fc] + 1'b1;
      end
      if (state_r == BK_LINK) begin
        head_r[ac] <= link_rdata[SlotW-1:0];
        head_v_r[ac] <= link_rdata[SlotW];
      end
    end
    if (q_valid && q_ready) begin
      mode_r <= q_data[QW-1];
      big_r <= q_data[QW-2];
      cls_r <= q_data[QW-3 -: 3];
      addr_r <= q_data[39:0];
    end
    if (exec_go) begin
      o_addr_r <= '0;
      o_cls_r <= '0;
      o_alloc_r <= '0;
      o_free_r <= '0;
      if (mode_r == MODE_ALLOC) begin
        if (big_r) o_status_r <= ST_TOO_LARGE;
        else begin
          o_cls_r <= cls_r;
          o_free_r <= free_cnt_r[ac];
          if (head_v_r[ac]) begin
            o_status_r <= ST_OK;
            o_addr_r <= pool_base + (40'(head_r[ac]) << MinW);
            o_alloc_r <= alloc_cnt_r[ac] + 1'b1;
          end else if (carve_rem_r[ac] != '0) begin
            o_status_r <= ST_OK;
            o_addr_r <= pool_base + carve_off;
            o_alloc_r <= alloc_cnt_r[ac] + 1'b1;
          end else if (per != '0 && used_r < limit) begin
            o_status_r <= ST_OK;
            o_addr_r <= pool_base + fresh_off;
            o_alloc_r <= alloc_cnt_r[ac] + 1'b1;
          end else begin
            o_status_r <= ST_EXHAUSTED;
            o_alloc_r <= alloc_cnt_r[ac];
          end
        end
      end else if (addr_r == '0) o_status_r <= ST_NULL_FREE;
      else if (!f_ok) o_status_r <= ST_BAD_FREE;
      else begin
        o_status_r <= ST_OK;
        o_cls_r <= fcls;
        o_alloc_r <= alloc_cnt_r[fc];
        o_free_r <= free_cnt_r[fc] + 1'b1;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !rsp.valid) else $error("accept while result pending");
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(o_addr_r)) else $error("result dropped");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= SlabCntW'(PoolSlabs)) else $error("slab count overrun");
endmodule
`default_nettype wire

// ----- hw/rtl/size_class_free_list_allocator_core.sv -----
// path: a request is classified and queued in the front, then the back end runs execute, and an
// allocate that pops a free list adds a link read before the result is held
// the back end runs one request at a time and takes no new request until the result is taken,
// bound by the read then write of the per-class head and the next-link memory
// reset: synchronous active-low; all free lists empty, no slabs owned, counters zero,
// pool_base 8192 and slab_limit 64; the link memory needs no clearing
`default_nettype none
module size_class_free_list_allocator_core #(
  parameter int CLASS_COUNT = 8,
  parameter int SLAB_BYTES = 8192,
  parameter int POOL_SLABS = 64,
  parameter int MIN_BLOCK_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  scfl_req_if.sink         in_req,
  scfl_rsp_if.source       out_rsp,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [39:0] cfg_data
);
  import scfl_pkg::*;
  localparam int QW = 60;

  logic [39:0]   pool_base_r;
  logic [6:0]    slab_limit_r;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= 40'd8192;
      slab_limit_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_POOL_BASE)) pool_base_r <= cfg_data;
      else slab_limit_r <= cfg_data[6:0];
    end
  end

  scfl_front #(.ClassCount(CLASS_COUNT), .MinBlockBytes(MIN_BLOCK_BYTES), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

  scfl_back #(.ClassCount(CLASS_COUNT), .SlabBytes(SLAB_BYTES), .PoolSlabs(POOL_SLABS),
              .MinBlockBytes(MIN_BLOCK_BYTES), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .pool_base(pool_base_r), .slab_limit(slab_limit_r), .rsp(out_rsp));
endmodule
`default_nettype wire
